// File: sv/bdpc_pkg.sv
// Shared types and constants for the button debounce and press classifier.
`default_nettype none
package bdpc_pkg;

	localparam int TIME_W = 32;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 8;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VERY_LONG = 8'd3;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] SHORT_LIMIT_RST = 16'd1000;
	localparam logic [CFG_W-1:0] LONG_RST = 16'd3000;
	localparam logic [CFG_W-1:0] VERY_LONG_RST = 16'd5000;

	typedef enum logic [1:0] {
		EV_RELEASE = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG = 2'd2,
		EV_VLONG = 2'd3
	} ev_kind_t;

	typedef struct packed {
		logic raw_pressed;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [TIME_W-1:0] duration_ms;
		logic last_event;
	} evt_t;

	// One queued command: one or two events that share a duration.
	typedef struct packed {
		logic pair;
		ev_kind_t k0;
		ev_kind_t k1;
		logic [TIME_W-1:0] dur;
	} cmd_t;

	typedef struct packed {
		logic vld;
		cmd_t cmd;
	} qport_t;

endpackage
`default_nettype wire

// File: sv/button_debounce_press_classifier_top.sv
// Top level of the button debounce and press classifier.
//
// Channel   Direction  Handshake                  Payload
// sample    in         sample_valid/sample_ready  sample_t: raw_pressed, now_ms
// evt       out        evt_valid/evt_ready        evt_t: event_kind, duration_ms, last_event
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data (16 bit)
//
// The front end takes one sample transaction per cycle while the queue is not full, and
// updates the debounce state in that same cycle, so samples can arrive back to back. Each
// sample causes zero, one or two events; they enter a four-entry command queue as a single
// command. The back end drains the queue at one event per cycle through its output register
// while evt_ready allows it, so a sample with two events costs two output transactions.
// A stalled output fills the queue, and sample_ready drops only when the queue is full.
// Reset is asynchronous and active low; it restores the default thresholds and clears the
// debounce state. The configuration port is always ready.
`default_nettype none
module button_debounce_press_classifier_top
	import bdpc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	output logic sample_ready,
	input wire sample_t sample,
	output logic evt_valid,
	input wire logic evt_ready,
	output evt_t evt,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data
);

	// Command traffic between the two halves. A command carries the first event kind,
	// the second kind when there is a pair, and the shared duration.
	qport_t push, pop;
	logic q_full, pop_en;

	// Classifier: debounce, stable level tracking and one-shot long press flags.
	bdpc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.q_full(q_full),
		.push(push)
	);

	// Decoupling queue so that an output stall does not stop sampling right away.
	bdpc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(q_full),
		.pop_en(pop_en),
		.pop(pop)
	);

	// Emitter: splits a paired command into two event transactions, the second one
	// carrying the last_event mark.
	bdpc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop(pop),
		.pop_en(pop_en),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt)
	);

endmodule
`default_nettype wire

// File: sv/bdpc_front.sv
// Front end: configuration registers, debounce state and event classification.
`default_nettype none
module bdpc_front
	import bdpc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	output logic sample_ready,
	input wire sample_t sample,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	input wire logic q_full,
	output qport_t push
);

	logic [CFG_W-1:0] debounce_q, short_limit_q, long_q, very_long_q;
	logic stable_q, prev_raw_q, long_fired_q, very_long_fired_q;
	logic [TIME_W-1:0] db_start_q, press_start_q;

	logic acc, raw, flip, press, rel, stable_nx, lf_eff, vf_eff, fire_l, fire_v, is_short;
	logic [TIME_W-1:0] now, db_start, db_el, since, held;

	assign sample_ready = !q_full;
	assign cfg_ready = 1'b1;
	assign acc = sample_valid && sample_ready;

	always_comb begin
		raw = sample.raw_pressed;
		now = sample.now_ms;
		db_start = (raw != prev_raw_q) ? now : db_start_q;
		db_el = now - db_start;
		flip = (db_el > {{(TIME_W-CFG_W){1'b0}}, debounce_q}) && (raw != stable_q);
		press = flip && raw;
		rel = flip && !raw;
		stable_nx = flip ? raw : stable_q;
		since = now - press_start_q;
		held = press ? '0 : since;
		lf_eff = press ? 1'b0 : long_fired_q;
		vf_eff = press ? 1'b0 : very_long_fired_q;
		fire_l = stable_nx && !lf_eff && (held >= {{(TIME_W-CFG_W){1'b0}}, long_q});
		fire_v = stable_nx && !vf_eff && (held >= {{(TIME_W-CFG_W){1'b0}}, very_long_q});
		is_short = since < {{(TIME_W-CFG_W){1'b0}}, short_limit_q};

		push.cmd.k1 = rel ? EV_SHORT : EV_VLONG;
		if (rel) begin
			push.vld = acc;
			push.cmd.pair = is_short;
			push.cmd.k0 = EV_RELEASE;
			push.cmd.dur = since;
		end else begin
			push.vld = acc && (fire_l || fire_v);
			push.cmd.pair = fire_l && fire_v;
			push.cmd.k0 = fire_l ? EV_LONG : EV_VLONG;
			push.cmd.dur = held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			short_limit_q <= SHORT_LIMIT_RST;
			long_q <= LONG_RST;
			very_long_q <= VERY_LONG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_data;
				CFG_SHORT_LIMIT: short_limit_q <= cfg_data;
				CFG_LONG: long_q <= cfg_data;
				CFG_VERY_LONG: very_long_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b0;
			prev_raw_q <= 1'b0;
			db_start_q <= '0;
			press_start_q <= '0;
			long_fired_q <= 1'b0;
			very_long_fired_q <= 1'b0;
		end else if (acc) begin
			stable_q <= stable_nx;
			prev_raw_q <= raw;
			db_start_q <= db_start;
			if (press) begin
				press_start_q <= now;
			end
			long_fired_q <= lf_eff || fire_l;
			very_long_fired_q <= vf_eff || fire_v;
		end
	end

endmodule
`default_nettype wire

// File: sv/bdpc_queue.sv
// Small command queue between the classifier and the event emitter.
`default_nettype none
module bdpc_queue
	import bdpc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire qport_t push,
	output logic full,
	input wire logic pop_en,
	output qport_t pop
);

	cmd_t mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == QCW'(QDEPTH));
	assign do_push = push.vld && !full;
	assign do_pop = pop_en && (cnt_q != '0);
	assign pop.vld = (cnt_q != '0);
	assign pop.cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/bdpc_back.sv
// Back end: unpacks queued commands into single events on the output register.
`default_nettype none
module bdpc_back
	import bdpc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire qport_t pop,
	output logic pop_en,
	output logic evt_valid,
	input wire logic evt_ready,
	output evt_t evt
);

	logic evt_valid_q, pend_valid_q;
	evt_t evt_q;
	ev_kind_t pend_kind_q;
	logic [TIME_W-1:0] pend_dur_q;
	logic load;

	assign load = !evt_valid_q || evt_ready;
	assign pop_en = load && !pend_valid_q && pop.vld;
	assign evt_valid = evt_valid_q;
	assign evt = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				evt_valid_q <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				evt_valid_q <= pop.vld;
				pend_valid_q <= pop.vld && pop.cmd.pair;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				evt_q.event_kind <= pend_kind_q;
				evt_q.duration_ms <= pend_dur_q;
				evt_q.last_event <= 1'b1;
			end else begin
				evt_q.event_kind <= pop.cmd.k0;
				evt_q.duration_ms <= pop.cmd.dur;
				evt_q.last_event <= !pop.cmd.pair;
			end
		end
		if (pop_en) begin
			pend_kind_q <= pop.cmd.k1;
			pend_dur_q <= pop.cmd.dur;
		end
	end

endmodule
`default_nettype wire

// File: sv/bdpc_checker.sv
// Port-level checks for the button debounce and press classifier, with their bind.
`default_nettype none
module bdpc_checker
	import bdpc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic evt_valid,
	input wire logic evt_ready,
	input wire evt_t evt
);

	// A stalled event transaction holds its payload.
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(evt))
		else $error("event payload changed while stalled");

	// The first event of a pair is either a release or a long press.
	a_pair_head: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt.last_event |->
		evt.event_kind == EV_RELEASE || evt.event_kind == EV_LONG)
		else $error("unexpected kind for the first event of a pair");

	// A release that is not last is followed at once by a short press of equal duration.
	a_release_short: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && !evt.last_event && evt.event_kind == EV_RELEASE |=>
		evt_valid && evt.event_kind == EV_SHORT &&
		evt.duration_ms == $past(evt.duration_ms))
		else $error("release not followed by matching short press");

	// A long press that is not last is followed at once by a very long press.
	a_long_vlong: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && !evt.last_event && evt.event_kind == EV_LONG |=>
		evt_valid && evt.event_kind == EV_VLONG &&
		evt.duration_ms == $past(evt.duration_ms))
		else $error("long press not followed by matching very long press");

	// A short press always has a duration below the 16-bit limit.
	a_short_range: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt.event_kind == EV_SHORT |->
		evt.duration_ms[TIME_W-1:CFG_W] == '0)
		else $error("short press duration out of range");

endmodule

bind button_debounce_press_classifier_top bdpc_checker u_bdpc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.evt_valid(evt_valid),
	.evt_ready(evt_ready),
	.evt(evt)
);
`default_nettype wire
